FILE: rtl/core/led_blink_flash_controller_top_macros.svh
// Assertion macros used by the LED controller checker
`ifndef LED_BLINK_FLASH_CONTROLLER_TOP_MACROS_SVH
`define LED_BLINK_FLASH_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LBFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lbfc_pkg.sv
// Types and constants for the LED blink and flash controller
package lbfc_pkg;

    localparam int NUM_LEDS_DEF      = 4;
    localparam int DURATION_BITS_DEF = 16;

    localparam int PIN_W      = 4;
    localparam int IDX_W      = 2;
    localparam int FIELD_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] THROTTLE_RST = 16'd200;
    localparam logic [3:0]  EXEMPT_RST   = 4'b0001;
    localparam logic [3:0]  BLOCKED_RST  = 4'b0100;
    localparam logic        LEVEL_RST    = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE = 2'd0,
        CFG_EXEMPT   = 2'd1,
        CFG_BLOCKED  = 2'd2,
        CFG_LEVEL    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BASE_DARK   = 2'd0,
        BASE_STEADY = 2'd1,
        BASE_CYCLE  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_OFF   = 2'd0,
        KIND_ON    = 2'd1,
        KIND_BLINK = 2'd2,
        KIND_FLASH = 2'd3
    } t_kind;

    typedef struct packed {
        logic  step;
        logic  tick;
        logic  hit;
        t_kind kind;
    } t_chan_ctl;

endpackage

FILE: rtl/core/lbfc_in_if.sv
// Input channel: tick or command beats
interface lbfc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  led_index;
    logic [1:0]  command_kind;
    logic [15:0] period_time;
    logic [15:0] on_time;

    modport source (output valid, op, led_index, command_kind, period_time, on_time,
                    input ready);
    modport sink   (input valid, op, led_index, command_kind, period_time, on_time,
                    output ready);
endinterface

FILE: rtl/core/lbfc_out_if.sv
// Result channel: pin levels and command status
interface lbfc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pin_levels;
    logic       accepted;

    modport source (output valid, pin_levels, accepted, input ready);
    modport sink   (input valid, pin_levels, accepted, output ready);
endinterface

FILE: rtl/core/lbfc_channel.sv
// Per-LED mode, blink countdown and flash overlay state
module lbfc_channel #(
    parameter int DURATION_BITS = lbfc_pkg::DURATION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lbfc_pkg::t_chan_ctl      i_ctl,
    input  logic [DURATION_BITS-1:0] i_period,
    input  logic [DURATION_BITS-1:0] i_on_time,
    output logic                     o_next_lit
);
    import lbfc_pkg::*;

    t_mode                    r_mode,  n_mode;
    logic [DURATION_BITS-1:0] r_per,   n_per;
    logic [DURATION_BITS-1:0] r_on,    n_on;
    logic [DURATION_BITS-1:0] r_brem,  n_brem;
    logic                     r_blit,  n_blit;
    logic                     r_fact,  n_fact;
    logic [DURATION_BITS-1:0] r_frem,  n_frem;

    always_comb begin
        n_mode = r_mode;
        n_per  = r_per;
        n_on   = r_on;
        n_brem = r_brem;
        n_blit = r_blit;
        n_fact = r_fact;
        n_frem = r_frem;

        if (i_ctl.tick) begin
            if (n_brem != '0) n_brem = n_brem - 1'b1;
            if (n_frem != '0) n_frem = n_frem - 1'b1;
        end

        if (i_ctl.hit) begin
            case (i_ctl.kind)
                KIND_OFF: begin
                    n_mode = BASE_DARK;
                    n_fact = 1'b0;
                end
                KIND_ON: begin
                    n_mode = BASE_STEADY;
                    n_fact = 1'b0;
                end
                KIND_BLINK: begin
                    n_mode = BASE_CYCLE;
                    n_per  = i_period;
                    n_on   = i_on_time;
                    n_blit = 1'b1;
                    n_brem = i_on_time;
                    n_fact = 1'b0;
                end
                default: begin
                    n_fact = 1'b1;
                    n_frem = i_on_time;
                end
            endcase
        end

        // expiry pass
        if (n_fact && n_frem == '0) n_fact = 1'b0;
        if (n_mode == BASE_CYCLE && !n_fact && n_brem == '0) begin
            n_blit = !n_blit;
            if (n_blit)            n_brem = n_on;
            else if (n_per > n_on) n_brem = n_per - n_on;
            else                   n_brem = '0;
        end

        o_next_lit = n_fact || n_mode == BASE_STEADY || (n_mode == BASE_CYCLE && n_blit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= BASE_DARK;
            r_per  <= '0;
            r_on   <= '0;
            r_brem <= '0;
            r_blit <= 1'b0;
            r_fact <= 1'b0;
            r_frem <= '0;
        end else if (i_ctl.step) begin
            r_mode <= n_mode;
            r_per  <= n_per;
            r_on   <= n_on;
            r_brem <= n_brem;
            r_blit <= n_blit;
            r_fact <= n_fact;
            r_frem <= n_frem;
        end
    end

endmodule

FILE: rtl/core/led_blink_flash_controller_top.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the result stalls; the whole step is one
// pass from the state registers and the accepted beat into the result register.
// Reset: synchronous active low; clears time, channel state and history,
// and loads the register defaults (throttle 200 ticks, LED 0 exempt, LED 2 blocked).
module led_blink_flash_controller_top #(
    parameter int NUM_LEDS      = lbfc_pkg::NUM_LEDS_DEF,
    parameter int DURATION_BITS = lbfc_pkg::DURATION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lbfc_in_if.sink                             i_item,
    lbfc_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [lbfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lbfc_pkg::*;

    logic [15:0]       r_throttle;
    logic [3:0]        r_exempt;
    logic [3:0]        r_blocked;
    logic              r_level;

    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] r_last [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_last_vld;

    logic              r_out_valid;
    logic [PIN_W-1:0]  r_pins, n_pins;
    logic              r_acc;

    logic              beat;
    logic              is_cmd;
    logic [NUM_LEDS-1:0] sel;
    logic [NUM_LEDS-1:0] hit;
    logic              led_ok;
    logic [TIME_W-1:0] last_sel;
    logic              vld_sel;
    logic [TIME_W-1:0] elapsed;
    logic              cmd_ok;
    logic [NUM_LEDS-1:0] next_lit;
    logic [DURATION_BITS-1:0] dur_period;
    logic [DURATION_BITS-1:0] dur_on;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign beat   = i_item.valid && i_item.ready;
    assign is_cmd = i_item.op;

    assign dur_period = DURATION_BITS'(i_item.period_time);
    assign dur_on     = DURATION_BITS'(i_item.on_time);

    always_comb begin
        last_sel = '0;
        vld_sel  = 1'b0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            sel[i] = (32'(i_item.led_index) == i);
            if (sel[i]) begin
                last_sel = last_sel | r_last[i];
                vld_sel  = vld_sel | r_last_vld[i];
            end
        end
        led_ok  = |sel;
        elapsed = r_time - last_sel;
        cmd_ok  = led_ok && !r_blocked[i_item.led_index]
                  && !(!r_exempt[i_item.led_index] && vld_sel
                       && elapsed < TIME_W'(r_throttle));
        hit = (beat && is_cmd && cmd_ok) ? sel : '0;
    end

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_chan
        t_chan_ctl ctl;
        always_comb begin
            ctl.step = beat;
            ctl.tick = beat && !is_cmd;
            ctl.hit  = hit[g];
            ctl.kind = t_kind'(i_item.command_kind);
        end
        lbfc_channel #(.DURATION_BITS(DURATION_BITS)) u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_period   (dur_period),
            .i_on_time  (dur_on),
            .o_next_lit (next_lit[g])
        );
    end

    for (genvar p = 0; p < PIN_W; p++) begin : g_pin
        if (p < NUM_LEDS) begin : g_led
            assign n_pins[p] = (next_lit[p] && !r_blocked[p]) ? r_level : !r_level;
        end else begin : g_none
            assign n_pins[p] = !r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle <= THROTTLE_RST;
            r_exempt   <= EXEMPT_RST;
            r_blocked  <= BLOCKED_RST;
            r_level    <= LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THROTTLE: r_throttle <= i_cfg_data[15:0];
                CFG_EXEMPT:   r_exempt   <= i_cfg_data[3:0];
                CFG_BLOCKED:  r_blocked  <= i_cfg_data[3:0];
                CFG_LEVEL:    r_level    <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_last_vld <= '0;
            for (int i = 0; i < NUM_LEDS; i++) r_last[i] <= '0;
        end else if (beat) begin
            if (!is_cmd) r_time <= r_time + 1'b1;
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (hit[i]) begin
                    r_last[i]     <= r_time;
                    r_last_vld[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            r_pins <= n_pins;
            r_acc  <= |hit;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.pin_levels = r_pins;
    assign o_result.accepted   = r_acc;

endmodule

FILE: rtl/core/lbfc_checker.sv
// Port-level checks for the LED controller, bound to the top level
`include "led_blink_flash_controller_top_macros.svh"

module lbfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_op,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_pins,
    input logic       i_out_acc,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_index,
    input logic [15:0] i_cfg_data
);
    import lbfc_pkg::*;

    logic [3:0] r_blk;
    logic       r_lvl;
    logic       in_beat;

    assign in_beat = i_in_valid && i_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= BLOCKED_RST;
            r_lvl <= LEVEL_RST;
        end else if (i_cfg_we) begin
            if (t_cfg_idx'(i_cfg_index) == CFG_BLOCKED) r_blk <= i_cfg_data[3:0];
            if (t_cfg_idx'(i_cfg_index) == CFG_LEVEL)   r_lvl <= i_cfg_data[0];
        end
    end

    `LBFC_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_pins) && $stable(i_out_acc), "stalled result changed")
    `LBFC_ASSERT_IMPL(a_ready_free, !i_out_valid, i_in_ready, "input stalled with empty output")
    `LBFC_ASSERT_NEXT(a_tick_result, in_beat && !i_in_op, i_out_valid && !i_out_acc,
        "tick beat did not give an unaccepted result")
    `LBFC_ASSERT_IMPL(a_blocked_dark, i_out_valid,
        ((i_out_pins ^ {4{!r_lvl}}) & r_blk) == 4'b0000, "blocked LED lit")

endmodule

bind led_blink_flash_controller_top lbfc_checker u_lbfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.op),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pins  (o_result.pin_levels),
    .i_out_acc   (o_result.accepted),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
